// ===== src/unordered_key_table_defines.svh =====
// assertion macros used by the checker file
`ifndef UNORDERED_KEY_TABLE_DEFINES_SVH
`define UNORDERED_KEY_TABLE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define UKT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ukt assertion failed");

// next-cycle implication, checked while out of reset
`define UKT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ukt assertion failed");

`endif

// ===== src/ukt_pkg.sv =====
package ukt_pkg;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam int KEY_W = 32;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] key;
    } t_req;

    typedef struct packed {
        logic       hit;
        logic [5:0] position;
        logic       dropped;
        logic [6:0] entry_count;
    } t_rsp;

    // finished result handed from the sequencer to the output stage
    typedef struct packed {
        logic valid;
        t_rsp rsp;
    } t_done;

endpackage

// ===== src/ukt_ifs.sv =====
interface ukt_req_if import ukt_pkg::*;;
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ukt_rsp_if import ukt_pkg::*;;
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/unordered_key_table.sv =====
// channel  | dir | payload                                  | transaction
// ---------+-----+------------------------------------------+--------------------------
// i_req    | in  | opcode, key                              | valid && ready at clk edge
// o_rsp    | out | hit, position, dropped, entry_count      | valid && ready at clk edge
//
// one transaction at a time; n is the fill count when it is taken
// insert: no scan; search: scans up to n slots; delete: scans, then reads the last entry
// the single read port of the key memory scans one slot per cycle and sets the scan length
// i_rst_n is synchronous and clears the fill count; key slots stay unknown until written
// a result that waits on o_rsp.ready holds the last step until the output register frees up
module unordered_key_table import ukt_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ukt_req_if.sink   i_req,
    ukt_rsp_if.source o_rsp
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // memory port between the sequencer and the key store
    logic             w_wr_en;
    logic [IW-1:0]    w_wr_addr;
    logic [KEY_W-1:0] w_wr_data;
    logic             w_rd_en;
    logic [IW-1:0]    w_rd_addr;
    logic [KEY_W-1:0] w_rd_data;

    t_done w_done;
    logic  w_out_free;

    // output register
    logic r_out_valid;
    t_rsp r_out_rsp;

    // the sequencer may finish when the output slot is empty or drains now
    assign w_out_free = !r_out_valid || o_rsp.ready;

    ukt_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_out_free(w_out_free),
        .o_done    (w_done),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data)
    );

    // key store, one write and one registered read per cycle
    ukt_key_mem #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_key_mem (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    // result register decouples the sequencer from the response sink
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done.valid) begin
            r_out_rsp <= w_done.rsp;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out_rsp;

endmodule

// ===== src/ukt_key_mem.sv =====
module ukt_key_mem import ukt_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IW-1:0]    i_wr_addr,
    input  logic [KEY_W-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [IW-1:0]    i_rd_addr,
    output logic [KEY_W-1:0] o_rd_data
);

    logic [KEY_W-1:0] r_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/ukt_ctrl.sv =====
module ukt_ctrl import ukt_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ukt_req_if.sink          i_req,
    input  logic             i_out_free,
    output t_done            o_done,
    output logic             o_wr_en,
    output logic [IW-1:0]    o_wr_addr,
    output logic [KEY_W-1:0] o_wr_data,
    output logic             o_rd_en,
    output logic [IW-1:0]    o_rd_addr,
    input  logic [KEY_W-1:0] i_rd_data
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_DEL_RD   = 3'd2;
    localparam logic [2:0] S_DEL_WAIT = 3'd3;
    localparam logic [2:0] S_FIN      = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [1:0]       r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic [CW-1:0]    r_scan_idx, n_scan_idx;
    logic             r_cmp_pend, n_cmp_pend;
    logic [IW-1:0]    r_cmp_idx, n_cmp_idx;
    logic             r_hit, n_hit;
    logic [IW-1:0]    r_pos, n_pos;
    logic             r_dropped, n_dropped;
    logic [KEY_W-1:0] r_move, n_move;
    logic [IW-1:0]    w_last;

    assign w_last      = IW'(r_count - 1'b1);
    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_op       = r_op;
        n_key      = r_key;
        n_scan_idx = r_scan_idx;
        n_cmp_pend = r_cmp_pend;
        n_cmp_idx  = r_cmp_idx;
        n_hit      = r_hit;
        n_pos      = r_pos;
        n_dropped  = r_dropped;
        n_move     = r_move;
        o_wr_en    = 1'b0;
        o_wr_addr  = IW'(r_count);
        o_wr_data  = r_key;
        o_rd_en    = 1'b0;
        o_rd_addr  = IW'(r_scan_idx);
        o_done     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op       = i_req.payload.opcode;
                    n_key      = i_req.payload.key;
                    n_hit      = 1'b0;
                    n_pos      = '0;
                    n_dropped  = 1'b0;
                    n_scan_idx = '0;
                    n_cmp_pend = 1'b0;
                    case (i_req.payload.opcode)
                        OP_INSERT: begin
                            if (r_count < CW'(TABLE_DEPTH)) begin
                                n_hit = 1'b1;
                                n_pos = IW'(r_count);
                            end else begin
                                n_dropped = 1'b1;
                            end
                            n_state = S_FIN;
                        end
                        OP_SEARCH, OP_DELETE: begin
                            n_state = (r_count == '0) ? S_FIN : S_SCAN;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue one read and compare the previous one each cycle
                o_rd_en    = (r_scan_idx < r_count);
                n_cmp_pend = o_rd_en;
                n_cmp_idx  = IW'(r_scan_idx);
                if (o_rd_en) begin
                    n_scan_idx = r_scan_idx + 1'b1;
                end
                if (r_cmp_pend && (i_rd_data == r_key)) begin
                    n_hit   = 1'b1;
                    n_pos   = r_cmp_idx;
                    n_state = (r_op == OP_DELETE) ? S_DEL_RD : S_FIN;
                end else if (r_cmp_pend && (r_cmp_idx == w_last)) begin
                    n_state = S_FIN;
                end
            end
            S_DEL_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = w_last;
                n_state   = S_DEL_WAIT;
            end
            S_DEL_WAIT: begin
                n_move  = i_rd_data;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    if ((r_op == OP_INSERT) && r_hit) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = IW'(r_count);
                        o_wr_data = r_key;
                        n_count   = r_count + 1'b1;
                    end else if ((r_op == OP_DELETE) && r_hit) begin
                        // last entry moves into the vacated slot
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_pos;
                        o_wr_data = r_move;
                        n_count   = r_count - 1'b1;
                    end
                    o_done.valid           = 1'b1;
                    o_done.rsp.hit         = r_hit;
                    o_done.rsp.position    = 6'(r_pos);
                    o_done.rsp.dropped     = r_dropped;
                    o_done.rsp.entry_count = 7'(n_count);
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_cmp_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_cmp_pend <= n_cmp_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_scan_idx <= n_scan_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_hit      <= n_hit;
        r_pos      <= n_pos;
        r_dropped  <= n_dropped;
        r_move     <= n_move;
    end

endmodule

// ===== src/ukt_checker.sv =====
`include "unordered_key_table_defines.svh"

module ukt_checker import ukt_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp
);

    // a miss always reports slot zero
    `UKT_ASSERT_IMP(a_miss_pos_zero, i_clk, i_rst_n, i_rsp_valid && !i_rsp.hit, i_rsp.position == 6'd0)

    // a refused insert only happens on a full table
    `UKT_ASSERT_IMP(a_drop_full, i_clk, i_rst_n, i_rsp_valid && i_rsp.dropped, !i_rsp.hit && (TABLE_DEPTH > 127 || i_rsp.entry_count == 7'(TABLE_DEPTH)))

    // fill count never passes the table depth
    `UKT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, i_rsp_valid, TABLE_DEPTH > 127 || i_rsp.entry_count <= 7'(TABLE_DEPTH))

    // a stalled result stays put
    `UKT_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp))

endmodule

bind unordered_key_table ukt_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_ukt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_rsp_valid(o_rsp.valid),
    .i_rsp_ready(o_rsp.ready),
    .i_rsp      (o_rsp.payload)
);

// ===== test/unordered_key_table_tb.sv =====
module unordered_key_table_tb;
    import ukt_pkg::*;

    localparam int DEPTH = 64;
    // opcode the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT = 5000;
    // long output hold-off that backs the block up
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 700;

    // pacing 0: sender idles 27%, receiver 71%; 1: reversed; 2: no idling
    typedef struct {
        t_req req;
        int   pacing;
    } pending_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ukt_req_if req_if ();
    ukt_rsp_if rsp_if ();

    unordered_key_table #(.TABLE_DEPTH(DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #10 i_clk = ~i_clk;

    // shadow of the key table, advanced once per accepted request
    logic [31:0] shadow_keys [DEPTH];
    int          shadow_fill = 0;

    pending_item stim_queue [$];
    t_rsp        awaited_rsps [$];
    logic [31:0] key_pool [8];

    bit req_taken   = 1'b0;
    int cur_pacing  = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int stall_count = 0;
    int fail_count  = 0;

    // lowest slot below the fill count holding the key, DEPTH on a miss
    function automatic int shadow_find(logic [31:0] key);
        for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_keys[i] == key) return i;
        end
        return DEPTH;
    endfunction

    // apply one operation to the shadow table and return the response it must give
    function automatic t_rsp apply_table_op(t_req req);
        t_rsp rsp;
        int   slot;
        rsp = '0;
        case (req.opcode)
            OP_INSERT: begin
                if (shadow_fill < DEPTH) begin
                    shadow_keys[shadow_fill] = req.key;
                    rsp.hit      = 1'b1;
                    rsp.position = shadow_fill[5:0];
                    shadow_fill++;
                end else begin
                    // full table, key is refused
                    rsp.dropped = 1'b1;
                end
            end
            OP_SEARCH: begin
                slot = shadow_find(req.key);
                if (slot < DEPTH) begin
                    rsp.hit      = 1'b1;
                    rsp.position = slot[5:0];
                end
            end
            OP_DELETE: begin
                slot = shadow_find(req.key);
                if (slot < DEPTH) begin
                    rsp.hit      = 1'b1;
                    rsp.position = slot[5:0];
                    // last entry fills the hole, may copy onto itself
                    shadow_keys[slot] = shadow_keys[shadow_fill - 1];
                    shadow_fill--;
                end
            end
            default: ;
        endcase
        rsp.entry_count = shadow_fill[6:0];
        return rsp;
    endfunction

    function automatic int idle_pct(int pacing, bit sender);
        case (pacing)
            0:       return sender ? 27 : 71;
            1:       return sender ? 71 : 27;
            default: return 0;
        endcase
    endfunction

    // mostly keys from a small pool so searches and deletes hit
    function automatic logic [31:0] pick_key();
        if ($urandom_range(99) < 75) return key_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    task automatic add_item(input logic [1:0] opcode, input logic [31:0] key, input int pacing);
        pending_item item;
        item.req.opcode = opcode;
        item.req.key    = key;
        item.pacing     = pacing;
        stim_queue.push_back(item);
    endtask

    // request driver: holds an offered transaction until it is taken
    always @(negedge i_clk) begin
        pending_item item;
        if (i_rst_n !== 1'b1) begin
            req_if.valid   <= 1'b0;
            req_if.payload <= '0;
        end else if (!req_if.valid || req_taken) begin
            if (stim_queue.size() > 0 &&
                $urandom_range(99) >= idle_pct(stim_queue[0].pacing, 1'b1)) begin
                item = stim_queue.pop_front();
                req_if.valid   <= 1'b1;
                req_if.payload <= item.req;
                cur_pacing     <= item.pacing;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // response receiver with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            rsp_if.ready <= 1'b0;
        end else begin
            // sender runs flat out in the last pacing, so the block backs up
            if (cur_pacing == 2 && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= idle_pct(cur_pacing, 1'b0));
            end
        end
    end

    // monitor: predicts on each request transaction, checks each response transaction
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (i_rst_n === 1'b1) begin
            req_taken = req_if.valid && req_if.ready;
            if (req_taken) awaited_rsps.push_back(apply_table_op(req_if.payload));
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.payload;
                if (awaited_rsps.size() == 0) begin
                    $error("response with none outstanding: hit %0d position %0d",
                           got.hit, got.position);
                    fail_count++;
                end else begin
                    want = awaited_rsps.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.position !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position, got.position);
                        fail_count++;
                    end
                    if (got.dropped !== want.dropped) begin
                        $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
                        fail_count++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                stall_count = 0;
            end else begin
                stall_count++;
                if (stall_count >= STALL_LIMIT) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    initial begin
        int count;
        int span;
        int pacing;
        int pick;
        int roll;
        logic [1:0] opcode;

        // known levels on every input before the first edge
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

        // directed: empty table, extremes, duplicates, delete corners
        add_item(OP_SEARCH, 32'h0000_0005, 0);
        add_item(OP_DELETE, 32'h0000_0005, 0);
        add_item(OP_UNUSED, 32'hFFFF_FFFF, 0);
        add_item(OP_INSERT, 32'h8000_0000, 0);
        add_item(OP_INSERT, 32'h7FFF_FFFF, 0);
        add_item(OP_INSERT, 32'h0000_0000, 0);
        add_item(OP_INSERT, 32'hFFFF_FFFF, 0);
        add_item(OP_INSERT, 32'h7FFF_FFFF, 0);
        // duplicate: first match wins
        add_item(OP_SEARCH, 32'h7FFF_FFFF, 0);
        add_item(OP_SEARCH, 32'hFFFF_FFFF, 0);
        add_item(OP_SEARCH, 32'h7FFF_FFFE, 0);
        add_item(OP_SEARCH, 32'h8000_0001, 0);
        // slot 0 removed, last entry moves down
        add_item(OP_DELETE, 32'h8000_0000, 0);
        add_item(OP_SEARCH, 32'h7FFF_FFFF, 0);
        // last slot removed, copied onto itself
        add_item(OP_DELETE, 32'hFFFF_FFFF, 0);
        add_item(OP_DELETE, 32'h1234_5678, 0);
        add_item(OP_UNUSED, 32'h0000_0000, 0);
        add_item(OP_SEARCH, 32'h0000_0000, 0);
        add_item(OP_DELETE, 32'h7FFF_FFFF, 0);
        add_item(OP_SEARCH, 32'h7FFF_FFFF, 0);

        // random episodes: fill past full, mixed churn, drain
        count = 0;
        while (count < RANDOM_ITEMS) begin
            pacing = count * 3 / RANDOM_ITEMS;
            pick   = (count == 0) ? 0 : $urandom_range(9);
            if (pick < 3) begin
                span = 60 + $urandom_range(10);
                for (int i = 0; i < span; i++) begin
                    opcode = ($urandom_range(7) == 0) ? OP_SEARCH : OP_INSERT;
                    add_item(opcode, pick_key(), pacing);
                end
            end else if (pick < 6) begin
                span = 25;
                for (int i = 0; i < span; i++) begin
                    roll = $urandom_range(99);
                    if (roll < 35)      opcode = OP_INSERT;
                    else if (roll < 65) opcode = OP_SEARCH;
                    else if (roll < 93) opcode = OP_DELETE;
                    else                opcode = OP_UNUSED;
                    add_item(opcode, pick_key(), pacing);
                end
            end else begin
                span = 40;
                for (int i = 0; i < span; i++) begin
                    opcode = ($urandom_range(4) == 0) ? OP_SEARCH : OP_DELETE;
                    add_item(opcode, pick_key(), pacing);
                end
            end
            count += span;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain everything, then allow for a late extra response
        while (stim_queue.size() != 0 || req_if.valid || awaited_rsps.size() != 0)
            @(negedge i_clk);
        repeat (2 * DEPTH + 10) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
